/* sv/alarm_line_window_monitor_core_defines.svh */
// Assertion macros for the alarm line window monitor.
// Used by the RTL files in this folder; expects clock and reset in scope.
`ifndef ALARM_LINE_WINDOW_MONITOR_CORE_DEFINES_SVH
`define ALARM_LINE_WINDOW_MONITOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ALWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ALWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ALWM_ASSERT(lbl, prop, msg)
`define ALWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/alwm_pkg.sv */
// Shared constants and types of the alarm line window monitor.
// No dependencies; imported by every module of the block.
`default_nettype none

package alwm_pkg;

   localparam int LINES    = 4;
   // The number of samples per set must be a power of two: the mean is a shift.
   localparam int SAMPLES  = 16;
   localparam int SAMPLE_W = 12;
   localparam int WINDOW_W = 24;
   localparam int SUM_W    = $clog2(SAMPLES * 4095 + 1);
   localparam int CNT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SAMPLE_SHIFT = $clog2(SAMPLES);
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = WINDOW_W;

   localparam logic [SUM_W-1:0] SAMPLES_SUM = SUM_W'(SAMPLES);
   localparam logic [CNT_W-1:0] LAST_COUNT  = CNT_W'(SAMPLES - 1);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'hFFF000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LINE0 = 3'd0,
      CSR_WINDOW_LINE1 = 3'd1,
      CSR_WINDOW_LINE2 = 3'd2,
      CSR_WINDOW_LINE3 = 3'd3,
      CSR_ACTIVE_MASK  = 3'd4,
      CSR_SILENT_MASK  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic acc_en;
      logic last;
   } lane_ctl_type;

   typedef struct packed {
      logic s1_valid;
      logic armed;
      logic clear_acc;
   } merge_ctl_type;

endpackage

`default_nettype wire

/* sv/alarm_line_window_monitor_core.sv */
// Alarm line window monitor. Each item carries one 12-bit code per alarm line;
// items may arrive in every cycle, held off by req_stall. Four lanes add the codes
// of a set of 16 items, and on the item that completes a set the finished sums move
// to a holding stage; once the result register is free they are compared with the
// per-line windows and the verdicts load it. The per-line add sets the rate of one
// item per clock while req_stall is low. The holding stage and result register let
// one more completed set be taken while a result is stalled.
// Depends on alwm_pkg, alwm_lane, alwm_merge and the defines header.
`default_nettype none

`include "alarm_line_window_monitor_core_defines.svh"

module alarm_line_window_monitor_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [alwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [alwm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [alwm_pkg::SAMPLE_W-1:0]    req_sample_line0,
   input  wire logic [alwm_pkg::SAMPLE_W-1:0]    req_sample_line1,
   input  wire logic [alwm_pkg::SAMPLE_W-1:0]    req_sample_line2,
   input  wire logic [alwm_pkg::SAMPLE_W-1:0]    req_sample_line3,
   input  wire logic                             req_system_armed,
   input  wire logic                             req_clear_alarm,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [alwm_pkg::SAMPLE_W-1:0]         rsp_mean_line0,
   output logic [alwm_pkg::SAMPLE_W-1:0]         rsp_mean_line1,
   output logic [alwm_pkg::SAMPLE_W-1:0]         rsp_mean_line2,
   output logic [alwm_pkg::SAMPLE_W-1:0]         rsp_mean_line3,
   output logic [alwm_pkg::LINES-1:0]            rsp_violation_mask,
   output logic                                  rsp_contact_open,
   output logic                                  rsp_silent_alarm,
   output logic                                  rsp_loud_alarm
);
   import alwm_pkg::*;

   logic [WINDOW_W-1:0] window_ff [LINES];
   logic [WINDOW_W-1:0] window_in [LINES];
   logic [LINES-1:0]    active_ff;
   logic [LINES-1:0]    active_in;
   logic [LINES-1:0]    silent_mask_ff;
   logic [LINES-1:0]    silent_mask_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                armed_ff;
   logic                req_accept;
   logic                last;
   logic                adv;
   lane_ctl_type        lane_ctl;
   merge_ctl_type       merge_ctl;
   logic [LINES-1:0][SAMPLE_W-1:0] samples;
   logic [LINES-1:0][SAMPLE_W-1:0] lane_mean;
   logic [LINES-1:0]               lane_viol;
   logic [LINES-1:0][SAMPLE_W-1:0] rsp_mean;

   // Configuration registers.
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         window_in[k] = window_ff[k];
      end
      active_in      = active_ff;
      silent_mask_in = silent_mask_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LINE0: window_in[0]    = csr_write_data;
            CSR_WINDOW_LINE1: window_in[1]    = csr_write_data;
            CSR_WINDOW_LINE2: window_in[2]    = csr_write_data;
            CSR_WINDOW_LINE3: window_in[3]    = csr_write_data;
            CSR_ACTIVE_MASK:  active_in       = csr_write_data[LINES-1:0];
            CSR_SILENT_MASK:  silent_mask_in  = csr_write_data[LINES-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINES; k++) begin
            window_ff[k] <= WINDOW_RESET;
         end
         active_ff      <= '0;
         silent_mask_ff <= '0;
      end else begin
         window_ff      <= window_in;
         active_ff      <= active_in;
         silent_mask_ff <= silent_mask_in;
      end
   end

   // Input handshake and set counter.
   assign req_stall  = s1_valid_ff && !adv;
   assign req_accept = req_valid && !req_stall;
   assign last       = (count_ff == LAST_COUNT);

   always_comb begin
      count_in    = count_ff;
      s1_valid_in = s1_valid_ff && !adv;
      if (req_accept) begin
         count_in = last ? '0 : count_ff + CNT_W'(1);
         if (last) begin
            s1_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Only the item that completes a set decides whether the system is armed.
   always_ff @(posedge clock) begin
      if (req_accept && last) begin
         armed_ff <= req_system_armed;
      end
   end

   assign lane_ctl.acc_en = req_accept;
   assign lane_ctl.last   = last;

   assign samples[0] = req_sample_line0;
   assign samples[1] = req_sample_line1;
   assign samples[2] = req_sample_line2;
   assign samples[3] = req_sample_line3;

   for (genvar g = 0; g < LINES; g++) begin : g_lane
      alwm_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (samples[g]),
         .window (window_ff[g]),
         .active (active_ff[g]),
         .mean   (lane_mean[g]),
         .viol   (lane_viol[g])
      );
   end

   assign merge_ctl.s1_valid  = s1_valid_ff;
   assign merge_ctl.armed     = armed_ff;
   assign merge_ctl.clear_acc = req_accept && req_clear_alarm;

   alwm_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .ctl                (merge_ctl),
      .silent_mask        (silent_mask_ff),
      .lane_mean          (lane_mean),
      .lane_viol          (lane_viol),
      .rsp_stall          (rsp_stall),
      .adv                (adv),
      .rsp_valid          (rsp_valid),
      .rsp_mean           (rsp_mean),
      .rsp_violation_mask (rsp_violation_mask),
      .rsp_contact_open   (rsp_contact_open),
      .rsp_silent_alarm   (rsp_silent_alarm),
      .rsp_loud_alarm     (rsp_loud_alarm)
   );

   assign rsp_mean_line0 = rsp_mean[0];
   assign rsp_mean_line1 = rsp_mean[1];
   assign rsp_mean_line2 = rsp_mean[2];
   assign rsp_mean_line3 = rsp_mean[3];

   `ALWM_ASSERT(a_set_fill, !s1_valid_ff ##1 s1_valid_ff |-> $past(req_accept && last), "finished sums appeared without a completing item")
   `ALWM_ASSERT(a_count_wrap, req_accept && last |=> count_ff == '0, "set counter did not restart after the last item")
   `ALWM_ASSERT(a_open_mask, rsp_valid |-> rsp_contact_open == (|rsp_violation_mask), "contact open disagrees with the violation mask")
   `ALWM_ASSERT(a_silent_clear, rsp_valid && rsp_violation_mask == '0 |-> !rsp_silent_alarm, "silent alarm held without a violation")
   `ALWM_ASSERT_ALWAYS(a_no_overrun, s1_valid_ff && !adv |-> !req_accept, "item accepted while finished sums were blocked")

endmodule

`default_nettype wire

/* sv/alwm_lane.sv */
// One alarm line: sample accumulator, finished-sum register and window compare.
// Depends on alwm_pkg.
`default_nettype none

module alwm_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire alwm_pkg::lane_ctl_type        ctl,
   input  wire logic [alwm_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [alwm_pkg::WINDOW_W-1:0] window,
   input  wire logic                          active,
   output logic [alwm_pkg::SAMPLE_W-1:0]      mean,
   output logic                               viol
);
   import alwm_pkg::*;

   logic [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0] acc_in;
   logic [SUM_W-1:0] done_ff;
   logic [SUM_W-1:0] sum_next;
   logic [SUM_W-1:0] lo_lim;
   logic [SUM_W-1:0] hi_lim;

   assign sum_next = acc_ff + SUM_W'(sample);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_en) begin
         acc_in = ctl.last ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // The finished sum waits here until the merge stage takes it.
   always_ff @(posedge clock) begin
      if (ctl.acc_en && ctl.last) begin
         done_ff <= sum_next;
      end
   end

   // Comparing against threshold times SAMPLES is the exact averaged test.
   assign lo_lim = SUM_W'(window[SAMPLE_W-1:0]) * SAMPLES_SUM;
   assign hi_lim = SUM_W'(window[WINDOW_W-1:SAMPLE_W]) * SAMPLES_SUM;
   assign viol   = active && ((done_ff >= hi_lim) || (done_ff <= lo_lim));
   assign mean   = SAMPLE_W'(done_ff >> SAMPLE_SHIFT);

endmodule

`default_nettype wire

/* sv/alwm_merge.sv */
// Merge stage: combines the lane verdicts, keeps the alarm flags, holds the result.
// Depends on alwm_pkg.
`default_nettype none

module alwm_merge (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire alwm_pkg::merge_ctl_type                  ctl,
   input  wire logic [alwm_pkg::LINES-1:0]               silent_mask,
   input  wire logic [alwm_pkg::LINES-1:0][alwm_pkg::SAMPLE_W-1:0] lane_mean,
   input  wire logic [alwm_pkg::LINES-1:0]               lane_viol,
   input  wire logic                                     rsp_stall,
   output logic                                          adv,
   output logic                                          rsp_valid,
   output logic [alwm_pkg::LINES-1:0][alwm_pkg::SAMPLE_W-1:0] rsp_mean,
   output logic [alwm_pkg::LINES-1:0]                    rsp_violation_mask,
   output logic                                          rsp_contact_open,
   output logic                                          rsp_silent_alarm,
   output logic                                          rsp_loud_alarm
);
   import alwm_pkg::*;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic silent_ff;
   logic silent_in;
   logic loud_ff;
   logic loud_in;
   logic viol_any;
   logic silent_set;
   logic loud_set;
   logic silent_after;
   logic loud_after;
   logic [LINES-1:0][SAMPLE_W-1:0] mean_ff;
   logic [LINES-1:0] viol_ff;
   logic open_ff;
   logic silent_out_ff;
   logic loud_out_ff;

   assign adv = ctl.s1_valid && (!rsp_valid_ff || !rsp_stall);

   assign viol_any     = |lane_viol;
   assign silent_set   = ctl.armed && |(lane_viol & silent_mask);
   assign loud_set     = ctl.armed && |(lane_viol & ~silent_mask);
   assign silent_after = viol_any && (silent_ff || silent_set);
   assign loud_after   = loud_ff || loud_set;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      silent_in    = silent_ff;
      loud_in      = loud_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
         silent_in    = silent_after;
         loud_in      = loud_after;
      end
      // A clear of the loud flag on an item accepted at this edge comes after the merged set.
      if (ctl.clear_acc) begin
         loud_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         silent_ff    <= 1'b0;
         loud_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         silent_ff    <= silent_in;
         loud_ff      <= loud_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mean_ff       <= lane_mean;
         viol_ff       <= lane_viol;
         open_ff       <= viol_any;
         silent_out_ff <= silent_after;
         loud_out_ff   <= loud_after;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean           = mean_ff;
   assign rsp_violation_mask = viol_ff;
   assign rsp_contact_open   = open_ff;
   assign rsp_silent_alarm   = silent_out_ff;
   assign rsp_loud_alarm     = loud_out_ff;

endmodule

`default_nettype wire
